/* rtl/cfp_pkg.sv */
`default_nettype none

package cfp_pkg;

    // frame layout
    localparam logic [15:0] MIN_FRAME_BYTES = 16'd15;
    localparam logic [15:0] POS_SYNC_FIRST  = 16'd0;
    localparam logic [15:0] POS_SYNC_SECOND = 16'd1;
    localparam logic [15:0] POS_VERSION     = 16'd2;
    localparam logic [15:0] POS_FLAGS       = 16'd3;
    localparam logic [15:0] POS_TID_LO      = 16'd4;
    localparam logic [15:0] POS_TID_HI      = 16'd5;
    localparam logic [15:0] POS_COMMAND     = 16'd6;
    localparam logic [15:0] POS_INDEX       = 16'd7;
    localparam logic [15:0] POS_PLEN_LO     = 16'd8;
    localparam logic [15:0] POS_PLEN_HI     = 16'd9;
    localparam logic [15:0] HEADER_END      = 16'd10;
    localparam logic [16:0] LENGTH_OVERHEAD = 17'd11;
    localparam logic [15:0] POS_MAX         = 16'hFFFF;

    // status codes
    typedef logic [2:0] status_t;
    localparam status_t STATUS_OK           = 3'd0;
    localparam status_t STATUS_BAD_FRAME    = 3'd1;
    localparam status_t STATUS_BAD_CHECKSUM = 3'd2;
    localparam status_t STATUS_BAD_VERSION  = 3'd3;
    localparam status_t STATUS_BAD_LENGTH   = 3'd4;

    // result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // register map
    typedef logic [3:0] addr_t;
    localparam addr_t ADDR_SYNC_FIRST  = 4'h0;
    localparam addr_t ADDR_SYNC_SECOND = 4'h4;
    localparam addr_t ADDR_VERSION     = 4'h8;
    localparam addr_t ADDR_MAX_PAYLOAD = 4'hC;

    localparam logic [7:0]  RST_SYNC_FIRST  = 8'hAA;
    localparam logic [7:0]  RST_SYNC_SECOND = 8'hBB;
    localparam logic [7:0]  RST_VERSION     = 8'h01;
    localparam logic [15:0] RST_MAX_PAYLOAD = 16'd256;

endpackage

`default_nettype wire

/* rtl/command_frame_parser_top.sv */
// Command frame parser.
// Input channel (in_valid/in_ready): one frame byte per transfer, with
// frame_end high on the last byte, the XOR checksum. Output channel
// (out_valid/out_ready): a kind 0 result for every payload byte (offset ten
// onward) and one kind 1 summary per frame carrying the header fields and a
// status (ok, bad frame, bad checksum, bad version, bad length). Sync and
// header bytes produce no result.
// Each result is registered and shows at the output in the cycle after its
// byte is taken. While in_ready is high it takes one byte per cycle; the byte
// counter, running XOR and header capture update in the same cycle the byte
// is taken, feeding a single result register.
// in_ready is high while the result register is empty or being emptied, so
// while a result waits on a stalled receiver every byte is held off, header
// bytes included, until that result has been taken.
// Reset clears the frame state and the result valid flag and loads the
// configuration registers with their defaults (sync 0xAA 0xBB, version 1,
// max payload 256). The user must write the registers over the APB port only
// between frames, when no result is waiting; the block does not enforce it.
`default_nettype none

module command_frame_parser_top (
    input  wire               clk,
    input  wire               rst_n,
    // configuration
    input  wire               psel,
    input  wire               penable,
    input  wire               pwrite,
    input  wire  [3:0]        paddr,
    input  wire  [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // byte input
    input  wire               in_valid,
    output logic              in_ready,
    input  wire  [7:0]        in_byte,
    input  wire               frame_end,
    // results
    output logic              out_valid,
    input  wire               out_ready,
    output logic              kind,
    output logic [7:0]        payload_byte,
    output cfp_pkg::status_t  status,
    output logic [7:0]        version,
    output logic [7:0]        flags,
    output logic [15:0]       txn_tag,
    output logic [7:0]        cmd_code,
    output logic [7:0]        item_index,
    output logic [15:0]       payload_length
);
    import cfp_pkg::*;

    // configuration registers
    logic [7:0]  sync_first_reg;
    logic [7:0]  sync_second_reg;
    logic [7:0]  exp_version_reg;
    logic [15:0] max_payload_reg;

    // frame state
    logic [15:0] pos_reg, pos_next;
    logic [7:0]  xor_reg, xor_next;
    logic        sync_good_reg, sync_good_next;
    logic [7:0]  hdr_version_reg, hdr_version_next;
    logic [7:0]  hdr_flags_reg, hdr_flags_next;
    logic [15:0] hdr_tid_reg, hdr_tid_next;
    logic [7:0]  hdr_command_reg, hdr_command_next;
    logic [7:0]  hdr_index_reg, hdr_index_next;
    logic [15:0] hdr_plen_reg, hdr_plen_next;

    // result register
    logic        out_valid_reg, out_valid_next;
    logic        kind_reg;
    logic [7:0]  payload_byte_reg;
    status_t     status_reg;
    logic [7:0]  version_reg;
    logic [7:0]  flags_reg;
    logic [15:0] tid_reg;
    logic [7:0]  command_reg;
    logic [7:0]  index_reg;
    logic [15:0] plen_reg;

    logic        cfg_write;
    logic        accept;
    logic        is_payload;
    logic        produce;
    logic [16:0] frame_len;
    logic        saturated;
    logic        len_bad;
    status_t     summary_status;

    // ---------------------------------------------------------------
    // configuration port
    // ---------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= RST_SYNC_FIRST;
            sync_second_reg <= RST_SYNC_SECOND;
            exp_version_reg <= RST_VERSION;
            max_payload_reg <= RST_MAX_PAYLOAD;
        end
        else if (cfg_write)
        begin
            case (paddr)
                ADDR_SYNC_FIRST:  sync_first_reg  <= pwdata[7:0];
                ADDR_SYNC_SECOND: sync_second_reg <= pwdata[7:0];
                ADDR_VERSION:     exp_version_reg <= pwdata[7:0];
                ADDR_MAX_PAYLOAD: max_payload_reg <= pwdata[15:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr)
            ADDR_SYNC_FIRST:  prdata = {24'd0, sync_first_reg};
            ADDR_SYNC_SECOND: prdata = {24'd0, sync_second_reg};
            ADDR_VERSION:     prdata = {24'd0, exp_version_reg};
            ADDR_MAX_PAYLOAD: prdata = {16'd0, max_payload_reg};
            default:          prdata = 32'd0;
        endcase
    end

    // ---------------------------------------------------------------
    // byte handling
    // ---------------------------------------------------------------
    assign in_ready   = !out_valid_reg || out_ready;
    assign accept     = in_valid && in_ready;
    assign is_payload = (pos_reg >= HEADER_END);
    assign produce    = accept && (frame_end || is_payload);

    // the saturated position gives exactly 0x10000 here
    assign frame_len  = {1'b0, pos_reg} + 17'd1;
    assign saturated  = (pos_reg == POS_MAX);
    assign len_bad    = (hdr_plen_reg == 16'd0) || (hdr_plen_reg > max_payload_reg)
                        || saturated
                        || (({1'b0, hdr_plen_reg} + LENGTH_OVERHEAD) != frame_len);

    always_comb
    begin
        if (frame_len < {1'b0, MIN_FRAME_BYTES} || !sync_good_reg)
            summary_status = STATUS_BAD_FRAME;
        else if (xor_reg != in_byte)
            summary_status = STATUS_BAD_CHECKSUM;
        else if (hdr_version_reg != exp_version_reg)
            summary_status = STATUS_BAD_VERSION;
        else if (len_bad)
            summary_status = STATUS_BAD_LENGTH;
        else
            summary_status = STATUS_OK;
    end

    always_comb
    begin
        pos_next         = pos_reg;
        xor_next         = xor_reg;
        sync_good_next   = sync_good_reg;
        hdr_version_next = hdr_version_reg;
        hdr_flags_next   = hdr_flags_reg;
        hdr_tid_next     = hdr_tid_reg;
        hdr_command_next = hdr_command_reg;
        hdr_index_next   = hdr_index_reg;
        hdr_plen_next    = hdr_plen_reg;

        if (accept)
        begin
            if (frame_end)
            begin
                // back to the start of a frame
                pos_next         = 16'd0;
                xor_next         = 8'd0;
                sync_good_next   = 1'b1;
                hdr_version_next = 8'd0;
                hdr_flags_next   = 8'd0;
                hdr_tid_next     = 16'd0;
                hdr_command_next = 8'd0;
                hdr_index_next   = 8'd0;
                hdr_plen_next    = 16'd0;
            end
            else
            begin
                if (!saturated)
                    pos_next = pos_reg + 16'd1;
                if (pos_reg > POS_SYNC_SECOND)
                    xor_next = xor_reg ^ in_byte;
                case (pos_reg)
                    POS_SYNC_FIRST:
                        if (in_byte != sync_first_reg)
                            sync_good_next = 1'b0;
                    POS_SYNC_SECOND:
                        if (in_byte != sync_second_reg)
                            sync_good_next = 1'b0;
                    POS_VERSION: hdr_version_next     = in_byte;
                    POS_FLAGS:   hdr_flags_next       = in_byte;
                    POS_TID_LO:  hdr_tid_next[7:0]    = in_byte;
                    POS_TID_HI:  hdr_tid_next[15:8]   = in_byte;
                    POS_COMMAND: hdr_command_next     = in_byte;
                    POS_INDEX:   hdr_index_next       = in_byte;
                    POS_PLEN_LO: hdr_plen_next[7:0]   = in_byte;
                    POS_PLEN_HI: hdr_plen_next[15:8]  = in_byte;
                    default:     ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= 16'd0;
            xor_reg         <= 8'd0;
            sync_good_reg   <= 1'b1;
            hdr_version_reg <= 8'd0;
            hdr_flags_reg   <= 8'd0;
            hdr_tid_reg     <= 16'd0;
            hdr_command_reg <= 8'd0;
            hdr_index_reg   <= 8'd0;
            hdr_plen_reg    <= 16'd0;
        end
        else
        begin
            pos_reg         <= pos_next;
            xor_reg         <= xor_next;
            sync_good_reg   <= sync_good_next;
            hdr_version_reg <= hdr_version_next;
            hdr_flags_reg   <= hdr_flags_next;
            hdr_tid_reg     <= hdr_tid_next;
            hdr_command_reg <= hdr_command_next;
            hdr_index_reg   <= hdr_index_next;
            hdr_plen_reg    <= hdr_plen_next;
        end
    end

    // ---------------------------------------------------------------
    // result register
    // ---------------------------------------------------------------
    always_comb
    begin
        if (produce)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (produce)
        begin
            if (frame_end)
            begin
                kind_reg         <= KIND_SUMMARY;
                payload_byte_reg <= 8'd0;
                status_reg       <= summary_status;
                version_reg      <= hdr_version_reg;
                flags_reg        <= hdr_flags_reg;
                tid_reg          <= hdr_tid_reg;
                command_reg      <= hdr_command_reg;
                index_reg        <= hdr_index_reg;
                plen_reg         <= hdr_plen_reg;
            end
            else
            begin
                kind_reg         <= KIND_PAYLOAD;
                payload_byte_reg <= in_byte;
                status_reg       <= STATUS_OK;
                version_reg      <= 8'd0;
                flags_reg        <= 8'd0;
                tid_reg          <= 16'd0;
                command_reg      <= 8'd0;
                index_reg        <= 8'd0;
                plen_reg         <= 16'd0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign kind           = kind_reg;
    assign payload_byte   = payload_byte_reg;
    assign status         = status_reg;
    assign version        = version_reg;
    assign flags          = flags_reg;
    assign txn_tag        = tid_reg;
    assign cmd_code       = command_reg;
    assign item_index     = index_reg;
    assign payload_length = plen_reg;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    // the last byte leaves the frame state at its start values
    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && frame_end) |=> (pos_reg == 16'd0 && xor_reg == 8'd0
                                   && sync_good_reg && hdr_plen_reg == 16'd0))
        else $error("frame state not cleared after last byte");

    // a payload byte leaves a kind 0 result with empty header fields
    a_payload_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !frame_end && is_payload) |=>
            (out_valid && kind == KIND_PAYLOAD && status == STATUS_OK
             && payload_length == 16'd0 && txn_tag == 16'd0))
        else $error("payload byte did not yield a payload result");

    // an ok summary never carries a zero payload length
    a_ok_summary_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == KIND_SUMMARY && status == STATUS_OK) |->
            (payload_length != 16'd0 && payload_byte == 8'd0))
        else $error("ok summary with zero payload length");

    // header bytes never produce a result
    a_header_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !frame_end && !is_payload && !out_valid_reg) |=> !out_valid)
        else $error("header byte produced a result");

endmodule

`default_nettype wire

/* tb/sv/frame_result_checker.sv */
module frame_result_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    input  logic [31:0]       prdata,
    input  logic              pready,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [7:0]        in_byte,
    input  logic              frame_end,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic              kind,
    input  logic [7:0]        payload_byte,
    input  cfp_pkg::status_t  status,
    input  logic [7:0]        version,
    input  logic [7:0]        flags,
    input  logic [15:0]       txn_tag,
    input  logic [7:0]        cmd_code,
    input  logic [7:0]        item_index,
    input  logic [15:0]       payload_length,
    output int                failures,
    output int                outstanding,
    output int                results_checked
);
    import cfp_pkg::*;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        status_t     status;
        logic [7:0]  version;
        logic [7:0]  flags;
        logic [15:0] txn_tag;
        logic [7:0]  cmd_code;
        logic [7:0]  item_index;
        logic [15:0] payload_length;
    } frame_result_t;

    frame_result_t frame_results_due[$];
    frame_result_t oldest;

    // register copies
    logic [7:0]  cfg_sync0;
    logic [7:0]  cfg_sync1;
    logic [7:0]  cfg_version;
    logic [15:0] cfg_max_payload;

    // frame state
    logic [15:0] byte_pos;
    logic [7:0]  xor_acc;
    logic        sync_ok;
    logic [63:0] header_bytes;

    task automatic report_mismatch(input string what);
        begin
            if (failures < 30)
                $display("mismatch at %0t: %s", $time, what);
            failures++;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        begin
            if (got !== want)
                report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
        end
    endtask

    task automatic clear_frame();
        begin
            byte_pos     = '0;
            xor_acc      = '0;
            sync_ok      = 1'b1;
            header_bytes = '0;
        end
    endtask

    task automatic parse_frame_byte(input logic [7:0] b, input logic last);
        frame_result_t r;
        logic [16:0]   frame_len;
        logic [15:0]   plen;
        logic          saturated;
        int            hdr_off;
        begin
            r = '0;
            if (!last)
            begin
                if (byte_pos == POS_SYNC_FIRST)
                begin
                    if (b != cfg_sync0)
                        sync_ok = 1'b0;
                end
                else if (byte_pos == POS_SYNC_SECOND)
                begin
                    if (b != cfg_sync1)
                        sync_ok = 1'b0;
                end
                else
                begin
                    xor_acc = xor_acc ^ b;
                    if (byte_pos < HEADER_END)
                    begin
                        hdr_off = int'(byte_pos) - 2;
                        header_bytes[hdr_off*8 +: 8] = header_bytes[hdr_off*8 +: 8] | b;
                    end
                    else
                    begin
                        r.kind         = KIND_PAYLOAD;
                        r.payload_byte = b;
                        frame_results_due.push_back(r);
                    end
                end
                if (byte_pos != POS_MAX)
                    byte_pos = byte_pos + 16'd1;
            end
            else
            begin
                saturated = (byte_pos == POS_MAX);
                frame_len = saturated ? 17'h10000 : {1'b0, byte_pos} + 17'd1;
                plen      = header_bytes[63:48];
                if (frame_len < {1'b0, MIN_FRAME_BYTES} || !sync_ok)
                    r.status = STATUS_BAD_FRAME;
                else if (xor_acc != b)
                    r.status = STATUS_BAD_CHECKSUM;
                else if (header_bytes[7:0] != cfg_version)
                    r.status = STATUS_BAD_VERSION;
                else if (plen == 16'd0 || plen > cfg_max_payload || saturated ||
                         LENGTH_OVERHEAD + {1'b0, plen} != frame_len)
                    r.status = STATUS_BAD_LENGTH;
                else
                    r.status = STATUS_OK;
                r.kind           = KIND_SUMMARY;
                r.version        = header_bytes[7:0];
                r.flags          = header_bytes[15:8];
                r.txn_tag        = header_bytes[31:16];
                r.cmd_code       = header_bytes[39:32];
                r.item_index     = header_bytes[47:40];
                r.payload_length = plen;
                frame_results_due.push_back(r);
                clear_frame();
            end
        end
    endtask

    function automatic logic [31:0] register_value(input logic [3:0] a);
        case (a)
            ADDR_SYNC_FIRST:  return {24'h0, cfg_sync0};
            ADDR_SYNC_SECOND: return {24'h0, cfg_sync1};
            ADDR_VERSION:     return {24'h0, cfg_version};
            ADDR_MAX_PAYLOAD: return {16'h0, cfg_max_payload};
            default:          return 32'h0;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_results_due.delete();
            cfg_sync0       = RST_SYNC_FIRST;
            cfg_sync1       = RST_SYNC_SECOND;
            cfg_version     = RST_VERSION;
            cfg_max_payload = RST_MAX_PAYLOAD;
            clear_frame();
            failures        = 0;
            results_checked = 0;
            outstanding    <= 0;
        end
        else
        begin
            // output transfer belongs to an earlier byte, so pop before push
            if (out_valid && out_ready)
            begin
                if (frame_results_due.size() == 0)
                    report_mismatch($sformatf("result with none expected, kind %0d", kind));
                else
                begin
                    oldest = frame_results_due.pop_front();
                    check_field("kind", 32'(kind), 32'(oldest.kind));
                    check_field("payload_byte", 32'(payload_byte),
                                32'(oldest.payload_byte));
                    check_field("status", 32'(status), 32'(oldest.status));
                    check_field("version", 32'(version), 32'(oldest.version));
                    check_field("flags", 32'(flags), 32'(oldest.flags));
                    check_field("txn_tag", 32'(txn_tag), 32'(oldest.txn_tag));
                    check_field("cmd_code", 32'(cmd_code), 32'(oldest.cmd_code));
                    check_field("item_index", 32'(item_index), 32'(oldest.item_index));
                    check_field("payload_length", 32'(payload_length),
                                32'(oldest.payload_length));
                    results_checked++;
                end
            end

            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    case (paddr)
                        ADDR_SYNC_FIRST:  cfg_sync0       = pwdata[7:0];
                        ADDR_SYNC_SECOND: cfg_sync1       = pwdata[7:0];
                        ADDR_VERSION:     cfg_version     = pwdata[7:0];
                        ADDR_MAX_PAYLOAD: cfg_max_payload = pwdata[15:0];
                        default:          ;
                    endcase
                end
                else
                    check_field($sformatf("prdata @%0h", paddr), prdata, register_value(paddr));
            end

            if (in_valid && in_ready)
                parse_frame_byte(in_byte, frame_end);

            outstanding <= frame_results_due.size();
        end
    end

endmodule

/* tb/sv/testbench.sv */
module testbench;
    import cfp_pkg::*;

    localparam int WATCHDOG_LIMIT = 500;
    localparam int PHASE_BYTES    = 20;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [3:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic        in_valid  = 1'b0;
    logic [7:0]  in_byte   = '0;
    logic        frame_end = 1'b0;
    logic        out_ready = 1'b0;

    logic [31:0] prdata;
    logic        pready;
    logic        in_ready;
    logic        out_valid;
    logic        kind;
    logic [7:0]  payload_byte;
    status_t     status;
    logic [7:0]  version;
    logic [7:0]  flags;
    logic [15:0] txn_tag;
    logic [7:0]  cmd_code;
    logic [7:0]  item_index;
    logic [15:0] payload_length;

    int failures;
    int outstanding;
    int results_checked;

    logic idle_on      = 1'b1;
    int   stall_left   = 0;
    int   quiet_cycles = 0;

    logic [7:0]  frame_q[$];
    logic [7:0]  cur_sync0       = RST_SYNC_FIRST;
    logic [7:0]  cur_sync1       = RST_SYNC_SECOND;
    logic [7:0]  cur_version     = RST_VERSION;
    logic [15:0] cur_max_payload = RST_MAX_PAYLOAD;
    int          frames_sent     = 0;
    int          bytes_sent      = 0;
    int          settings_used   = 1;

    command_frame_parser_top DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_byte        (in_byte),
        .frame_end      (frame_end),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .payload_byte   (payload_byte),
        .status         (status),
        .version        (version),
        .flags          (flags),
        .txn_tag        (txn_tag),
        .cmd_code       (cmd_code),
        .item_index     (item_index),
        .payload_length (payload_length)
    );

    frame_result_checker result_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_byte         (in_byte),
        .frame_end       (frame_end),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .kind            (kind),
        .payload_byte    (payload_byte),
        .status          (status),
        .version         (version),
        .flags           (flags),
        .txn_tag         (txn_tag),
        .cmd_code        (cmd_code),
        .item_index      (item_index),
        .payload_length  (payload_length),
        .failures        (failures),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // receiver back-pressure in bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 10);
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", quiet_cycles);
                $display("TB_ERROR");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        begin
            if (idle_on && $urandom_range(0, 11) == 0)
            begin
                in_valid  <= 1'b0;
                in_byte   <= 8'($urandom_range(0, 255));
                frame_end <= 1'($urandom_range(0, 1));
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            in_valid  <= 1'b1;
            in_byte   <= b;
            frame_end <= last;
            @(posedge clk);
            while (!in_ready) @(posedge clk);
            bytes_sent++;
        end
    endtask

    task automatic send_frame();
        int i;
        begin
            for (i = 0; i < frame_q.size(); i++)
                send_byte(frame_q[i], i == frame_q.size() - 1);
            frames_sent++;
        end
    endtask

    task automatic build_frame(input logic [7:0] s0, input logic [7:0] s1,
                               input logic [7:0] ver, input logic [7:0] flg,
                               input logic [15:0] tid, input logic [7:0] cmd,
                               input logic [7:0] idx, input logic [15:0] plen,
                               input int npay, input logic bad_sum);
        logic [7:0] sum;
        int         i;
        begin
            frame_q.delete();
            frame_q.push_back(s0);
            frame_q.push_back(s1);
            frame_q.push_back(ver);
            frame_q.push_back(flg);
            frame_q.push_back(tid[7:0]);
            frame_q.push_back(tid[15:8]);
            frame_q.push_back(cmd);
            frame_q.push_back(idx);
            frame_q.push_back(plen[7:0]);
            frame_q.push_back(plen[15:8]);
            for (i = 0; i < npay; i++)
                frame_q.push_back(8'($urandom_range(0, 255)));
            sum = '0;
            for (i = 2; i < frame_q.size(); i++)
                sum = sum ^ frame_q[i];
            if (bad_sum)
                sum = sum ^ 8'($urandom_range(1, 255));
            frame_q.push_back(sum);
        end
    endtask

    task automatic good_frame(input logic [15:0] plen, input int npay, input logic bad_sum);
        begin
            build_frame(cur_sync0, cur_sync1, cur_version, 8'($urandom_range(0, 255)),
                        16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)), plen, npay, bad_sum);
        end
    endtask

    task automatic cut_frame(input int keep);
        begin
            while (frame_q.size() > keep)
                void'(frame_q.pop_back());
        end
    endtask

    // sender holds off until every outstanding result has been taken
    task automatic drain();
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while (outstanding != 0) @(posedge clk);
            repeat (3) @(posedge clk);
        end
    endtask

    task automatic reg_access(input addr_t a, input logic wr, input logic [31:0] d);
        begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= wr;
            paddr   <= a;
            pwdata  <= d;
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            while (!pready) @(posedge clk);
            psel    <= 1'b0;
            penable <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic apply_settings(input logic [7:0] s0, input logic [7:0] s1,
                                  input logic [7:0] ver, input logic [15:0] maxp);
        begin
            drain();
            reg_access(ADDR_SYNC_FIRST, 1'b1, {24'h0, s0});
            reg_access(ADDR_SYNC_SECOND, 1'b1, {24'h0, s1});
            reg_access(ADDR_VERSION, 1'b1, {24'h0, ver});
            reg_access(ADDR_MAX_PAYLOAD, 1'b1, {16'h0, maxp});
            reg_access(ADDR_SYNC_FIRST, 1'b0, 32'h0);
            reg_access(ADDR_SYNC_SECOND, 1'b0, 32'h0);
            reg_access(ADDR_VERSION, 1'b0, 32'h0);
            reg_access(ADDR_MAX_PAYLOAD, 1'b0, 32'h0);
            cur_sync0       = s0;
            cur_sync1       = s1;
            cur_version     = ver;
            cur_max_payload = maxp;
            settings_used++;
        end
    endtask

    // lean on the max_payload boundary when the limit is small
    function automatic logic [15:0] pick_plen();
        if (cur_max_payload <= 16'd40 && $urandom_range(0, 2) == 0)
            return cur_max_payload;
        return 16'($urandom_range(4, 14));
    endfunction

    task automatic send_random_frame();
        int          pick;
        int          npay;
        logic [7:0]  s0;
        logic [7:0]  s1;
        logic [7:0]  ver;
        logic [15:0] plen;
        logic        bad_sum;
        begin
            pick    = $urandom_range(0, 99);
            s0      = cur_sync0;
            s1      = cur_sync1;
            ver     = cur_version;
            plen    = pick_plen();
            npay    = int'(plen);
            bad_sum = 1'b0;
            if (pick >= 60 && pick < 80)
            begin
                case ($urandom_range(0, 6))
                    0: s0 = s0 ^ 8'($urandom_range(1, 255));
                    1: s1 = s1 ^ 8'($urandom_range(1, 255));
                    2: bad_sum = 1'b1;
                    3: ver = ver ^ 8'($urandom_range(1, 255));
                    4: npay = ($urandom_range(0, 1) == 1) ? npay + 1 : npay - 1;
                    5: plen = 16'd0;
                    default:
                    begin
                        plen = cur_max_payload + 16'($urandom_range(1, 3));
                        npay = (plen <= 16'd60) ? int'(plen) : int'($urandom_range(4, 14));
                    end
                endcase
            end
            if (pick >= 90)
            begin
                // raw noise ending on a random byte
                frame_q.delete();
                repeat ($urandom_range(1, 30)) frame_q.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                build_frame(s0, s1, ver, 8'($urandom_range(0, 255)),
                            16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), plen, npay, bad_sum);
                if (pick >= 80)
                    cut_frame($urandom_range(1, frame_q.size() - 1));
            end
            send_frame();
        end
    endtask

    initial
    begin : stimulus
        int phase_start;
        int p;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values of the registers
        reg_access(ADDR_SYNC_FIRST, 1'b0, 32'h0);
        reg_access(ADDR_SYNC_SECOND, 1'b0, 32'h0);
        reg_access(ADDR_VERSION, 1'b0, 32'h0);
        reg_access(ADDR_MAX_PAYLOAD, 1'b0, 32'h0);

        // directed frames under reset settings
        build_frame(8'hAA, 8'hBB, 8'h01, 8'hFF, 16'hFFFF, 8'h00, 8'hFF, 16'd4, 4, 1'b0);
        send_frame();
        build_frame(8'hAA, 8'hBB, 8'h01, 8'h00, 16'h0000, 8'hFF, 8'h00, 16'd256, 256, 1'b0);
        send_frame();
        good_frame(16'd257, 257, 1'b0);
        send_frame();
        frame_q.delete();
        frame_q.push_back(8'h55);
        send_frame();
        good_frame(16'd0, 0, 1'b0);
        send_frame();
        good_frame(16'd3, 3, 1'b0);
        send_frame();
        build_frame(8'h55, 8'hBB, 8'h01, 8'h12, 16'h3456, 8'h78, 8'h9A, 16'd4, 4, 1'b0);
        send_frame();
        build_frame(8'hAA, 8'h44, 8'h01, 8'h12, 16'h3456, 8'h78, 8'h9A, 16'd4, 4, 1'b0);
        send_frame();
        good_frame(16'd6, 6, 1'b1);
        send_frame();
        build_frame(8'hAA, 8'hBB, 8'hFF, 8'h01, 16'h8001, 8'h02, 8'h03, 16'd5, 5, 1'b0);
        send_frame();
        // checksum outranks version
        build_frame(8'hAA, 8'hBB, 8'h00, 8'h01, 16'h8001, 8'h02, 8'h03, 16'd5, 5, 1'b1);
        send_frame();
        // sync outranks checksum
        build_frame(8'hAB, 8'hBB, 8'h01, 8'h01, 16'h0102, 8'h03, 8'h04, 16'd5, 5, 1'b1);
        send_frame();
        good_frame(16'd0, 4, 1'b0);
        send_frame();
        good_frame(16'd5, 4, 1'b0);
        send_frame();
        good_frame(16'd4, 4, 1'b0);
        cut_frame(6);
        send_frame();

        for (p = 0; p < 5; p++)
        begin
            case (p)
                0: apply_settings(RST_SYNC_FIRST, RST_SYNC_SECOND, RST_VERSION,
                                  RST_MAX_PAYLOAD);
                1: apply_settings(8'h00, 8'hFF, 8'h00, 16'd1);
                2: apply_settings(8'hFF, 8'h00, 8'hFF, 16'd65524);
                3: apply_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                  8'($urandom_range(0, 255)), 16'($urandom_range(4, 40)));
                default:
                begin
                    idle_on <= 1'b0;
                    apply_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                   8'($urandom_range(0, 255)),
                                   16'($urandom_range(1, 65524)));
                end
            endcase
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
            begin
                send_random_frame();
                if ($urandom_range(0, 9) == 0)
                    drain();
            end
        end

        drain();
        repeat (4) @(posedge clk);

        $display("covered %0d frames, %0d bytes under %0d register settings",
                 frames_sent, bytes_sent, settings_used);
        $display("%0d results checked, %0d mismatches", results_checked, failures);
        if (failures == 0 && outstanding == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
